### src/fpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types and constants for the piecewise fuzzy membership block.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 15;

  // most quotient bits resolved per divider stage; the last may resolve fewer
  localparam int unsigned DIV_STEPS = 4;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_D    = 3'd4;

  localparam logic [1:0] SEG_OUTSIDE = 2'd0;
  localparam logic [1:0] SEG_RISING  = 2'd1;
  localparam logic [1:0] SEG_PLATEAU = 2'd2;
  localparam logic [1:0] SEG_FALLING = 2'd3;

  // control travelling alongside the divider data
  typedef struct packed {
    logic       valid;
    logic [1:0] seg;
    logic       sat;
  } fpm_ctl_t;

endpackage
`default_nettype wire

### src/fpm_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpm_div_stage
// One registered stage of the restoring divider: resolves STEPS quotient bits.
// ----------------------------------------------------------------------------
module fpm_div_stage
  import fpm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned STEPS      = DIV_STEPS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fpm_ctl_t              ctl_i,
  input  wire logic [DATA_WIDTH:0]   den_i,
  input  wire logic [DATA_WIDTH:0]   rem_i,
  input  wire logic [FRAC_BITS-1:0]  quo_i,
  output fpm_ctl_t                   ctl_o,
  output logic [DATA_WIDTH:0]        den_o,
  output logic [DATA_WIDTH:0]        rem_o,
  output logic [FRAC_BITS-1:0]       quo_o
);

  logic [DATA_WIDTH:0]   rem_d, rem_q;
  logic [FRAC_BITS-1:0]  quo_d, quo_q;
  logic [DATA_WIDTH:0]   den_q;
  logic [DATA_WIDTH+1:0] trial;
  fpm_ctl_t              ctl_q;

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    trial = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_d, 1'b0};
      if (trial >= {1'b0, den_i}) begin
        trial = trial - {1'b0, den_i};
        quo_d = {quo_d[FRAC_BITS-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[FRAC_BITS-2:0], 1'b0};
      end
      rem_d = trial[DATA_WIDTH:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_i;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign ctl_o = ctl_q;
  assign den_o = den_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule
`default_nettype wire

### src/fuzzy_piecewise_membership.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_piecewise_membership
// Triangular / trapezoidal fuzzifier: membership degree and segment per sample.
// ----------------------------------------------------------------------------
// channel   ports                                   direction
// sample    start_i, busy_o, x_value_i              in
// result    done_o, degree_o, segment_o             out
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i        in
//
// One sample per cycle. Results pass through stage A, stage B, the
// restoring divider pipeline and the output register.
// busy_o stays low: the pipeline never stalls, results leave as one-cycle
// strobes. Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module fuzzy_piecewise_membership
  import fpm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [DATA_WIDTH-1:0] x_value_i,
  output logic                              done_o,
  output logic [FRAC_BITS:0]                degree_o,
  output logic [1:0]                        segment_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [DATA_WIDTH-1:0]        cfg_wdata_i
);

  localparam int unsigned NUM_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam logic [FRAC_BITS:0] ONE_VALUE = {1'b1, {FRAC_BITS{1'b0}}};

  // configuration registers
  logic                         mode_q;
  logic signed [DATA_WIDTH-1:0] pa_q, pb_q, pc_q, pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
      pd_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SHAPE_MODE: mode_q <= cfg_wdata_i[0];
        REG_POINT_A:    pa_q   <= cfg_wdata_i;
        REG_POINT_B:    pb_q   <= cfg_wdata_i;
        REG_POINT_C:    pc_q   <= cfg_wdata_i;
        REG_POINT_D:    pd_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage A: compares and differences
  logic                       va_q;
  logic                       le_a_q, le_b_q, le_c_q, le_d_q;
  logic signed [DATA_WIDTH:0] xa_q, ba_q, dx_q, dc_q, cx_q, cb_q;
  logic signed [DATA_WIDTH:0] x_ext, a_ext, b_ext, c_ext, d_ext;

  assign x_ext = {x_value_i[DATA_WIDTH-1], x_value_i};
  assign a_ext = {pa_q[DATA_WIDTH-1], pa_q};
  assign b_ext = {pb_q[DATA_WIDTH-1], pb_q};
  assign c_ext = {pc_q[DATA_WIDTH-1], pc_q};
  assign d_ext = {pd_q[DATA_WIDTH-1], pd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    le_a_q <= x_value_i <= pa_q;
    le_b_q <= x_value_i <= pb_q;
    le_c_q <= x_value_i <= pc_q;
    le_d_q <= x_value_i <= pd_q;
    xa_q   <= x_ext - a_ext;
    ba_q   <= b_ext - a_ext;
    dx_q   <= d_ext - x_ext;
    dc_q   <= d_ext - c_ext;
    cx_q   <= c_ext - x_ext;
    cb_q   <= c_ext - b_ext;
  end

  // stage B: segment select, operands, saturation
  fpm_ctl_t            ctl_d;
  logic [DATA_WIDTH:0] num_d, den_d;

  always_comb begin
    ctl_d       = '0;
    ctl_d.valid = va_q;
    ctl_d.seg   = SEG_OUTSIDE;
    num_d       = '0;
    den_d       = {{DATA_WIDTH{1'b0}}, 1'b1};
    priority if (le_a_q) begin
      ctl_d.seg = SEG_OUTSIDE;
    end else if (le_b_q) begin
      ctl_d.seg = SEG_RISING;
      num_d     = xa_q;
      den_d     = ba_q;
    end else if (mode_q) begin
      if (le_c_q) begin
        ctl_d.seg = SEG_PLATEAU;
        ctl_d.sat = 1'b1;
      end else if (le_d_q) begin
        ctl_d.seg = SEG_FALLING;
        num_d     = dx_q;
        den_d     = dc_q;
      end
    end else if (le_c_q) begin
      ctl_d.seg = SEG_FALLING;
      num_d     = cx_q;
      den_d     = cb_q;
    end else begin
      ctl_d.seg = SEG_OUTSIDE;
    end
    if (num_d == den_d) begin
      ctl_d.sat = 1'b1;
    end
  end

  fpm_ctl_t              ctl_s [NUM_STAGES+1];
  logic [DATA_WIDTH:0]   den_s [NUM_STAGES+1];
  logic [DATA_WIDTH:0]   rem_s [NUM_STAGES+1];
  logic [FRAC_BITS-1:0]  quo_s [NUM_STAGES+1];
  fpm_ctl_t              ctl_b_q;
  logic [DATA_WIDTH:0]   num_b_q, den_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else begin
      ctl_b_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_b_q <= num_d;
    den_b_q <= den_d;
  end

  assign ctl_s[0] = ctl_b_q;
  assign den_s[0] = den_b_q;
  assign rem_s[0] = num_b_q;
  assign quo_s[0] = '0;

  // divider pipeline
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_div
    localparam int unsigned LEFT  = FRAC_BITS - k * DIV_STEPS;
    localparam int unsigned STEPS = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;

    fpm_div_stage #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .STEPS      (STEPS)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[k]),
      .den_i  (den_s[k]),
      .rem_i  (rem_s[k]),
      .quo_i  (quo_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .den_o  (den_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .quo_o  (quo_s[k+1])
    );
  end

  // output register
  fpm_ctl_t            ctl_end;
  logic                done_q;
  logic [FRAC_BITS:0]  degree_q, degree_d;
  logic [1:0]          segment_q;

  assign ctl_end = ctl_s[NUM_STAGES];

  always_comb begin
    priority if (ctl_end.seg == SEG_OUTSIDE) begin
      degree_d = '0;
    end else if (ctl_end.sat) begin
      degree_d = ONE_VALUE;
    end else begin
      degree_d = {1'b0, quo_s[NUM_STAGES]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_end.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    degree_q  <= degree_d;
    segment_q <= ctl_end.seg;
  end

  assign busy_o    = 1'b0;
  assign done_o    = done_q;
  assign degree_o  = degree_q;
  assign segment_o = segment_q;

  // rem_s of the last stage is the final remainder, not needed
  logic unused_rem;
  assign unused_rem = ^rem_s[NUM_STAGES] ^ ^den_s[NUM_STAGES];

endmodule
`default_nettype wire
